@@ hw/rtl/wmmn_pkg.sv @@
// Shared types and constants of the weighted min-max normalizer.
// Field widths, action codes and fixed-point constants; no dependencies.
`timescale 1ns / 1ps

package wmmn_pkg;

	// Field widths of the request and result
	localparam int ACTION_W = 2;
	localparam int COL_W    = 4;
	localparam int SAMPLE_W = 32;
	localparam int WEIGHT_W = 16;
	localparam int NORM_W   = 24;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_CLEAR     = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD_WGT  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_OBSERVE   = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NORMALIZE = 2'd3;

	// Result status codes
	localparam logic STAT_OK      = 1'b0;
	localparam logic STAT_NO_DATA = 1'b1;

	// 1.0 in Q8.8, weight of a column never loaded
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'h0100;

	// Product width of offset times weight, and quotient bits produced
	localparam int PROD_W    = SAMPLE_W + WEIGHT_W;
	localparam int DIV_STEPS = NORM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

endpackage

@@ hw/rtl/weighted_min_max_normalizer_unit.sv @@
// Weighted min-max normalizer top level: per-column statistics memories,
// sequencer, one multiplier and a shared radix-2 divide step. Uses wmmn_pkg.
`timescale 1ns / 1ps

// Per-column weighted min-max scaling. A request carries an action for one
// column: clear all statistics, load a Q8.8 weight, observe a Q16.16 sample
// (widens the column's min and max), or normalize a sample, which returns
// clamp((x-min)/(max-min),0,1)*weight as unsigned Q8.16, truncated. Status 1
// means the column has no observed samples (or is out of range); a zero range
// gives 0 with status 0. The unit handles one request at a time. Clear and
// weight load finish in the accept cycle; observe goes through accept, a
// registered memory read, and compare and write back. Normalize goes through
// memory read, offset and range subtract, clamp, one 32x16 multiply, divider
// load, then a restoring divide step repeated to yield the 24 quotient bits
// one at a time, and the load of the output register once it is free. The
// result waits there, so a new request is taken while it is unread.
module weighted_min_max_normalizer_unit
	import wmmn_pkg::*;
#(
	parameter int COLUMNS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ACTION_W-1:0]        action,
	input  logic [COL_W-1:0]           column,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [WEIGHT_W-1:0]        weight,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [NORM_W-1:0]          normalized,
	output logic [COL_W-1:0]           result_column,
	output logic                       status
);

	localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EXE,
		ST_CLAMP,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                      state_q;
	logic [ACTION_W-1:0]         act_q;
	logic [COL_W-1:0]            col_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        col_ok_q;
	logic signed [SAMPLE_W-1:0]  sample_q;

	// Statistics and weight storage
	logic [SAMPLE_W-1:0]         min_mem [COLUMNS];
	logic [SAMPLE_W-1:0]         max_mem [COLUMNS];
	logic [WEIGHT_W-1:0]         wgt_mem [COLUMNS];
	logic [COLUMNS-1:0]          seen_q;
	logic [COLUMNS-1:0]          wset_q;
	logic signed [SAMPLE_W-1:0]  rd_min_q;
	logic signed [SAMPLE_W-1:0]  rd_max_q;
	logic [WEIGHT_W-1:0]         rd_wgt_q;
	logic                        rd_wset_q;

	// Datapath registers
	logic [SAMPLE_W-1:0]         range_q;
	logic signed [SAMPLE_W:0]    off_q;
	logic [SAMPLE_W-1:0]         offc_q;
	logic [PROD_W-1:0]           prod_q;
	logic [SAMPLE_W-1:0]         rem_q;
	logic [NORM_W-1:0]           num_lo_q;
	logic [NORM_W-1:0]           quo_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        stat_q;

	// Output register
	logic                        out_valid_q;
	logic [NORM_W-1:0]           normalized_q;
	logic [COL_W-1:0]            result_column_q;
	logic                        status_q;

	logic                        accept;
	logic [IDX_W-1:0]            in_idx;
	logic                        in_col_ok;
	logic                        mem_wr;
	logic                        out_load;
	logic [WEIGHT_W-1:0]         wgt_eff;
	logic [SAMPLE_W:0]           rem_ext;
	logic [SAMPLE_W+1:0]         rem_diff;
	logic                        div_ge;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign in_idx    = IDX_W'(column);
	assign in_col_ok = (32'(column) < COLUMNS);

	// Write back min and max on observe
	assign mem_wr = (state_q == ST_EXE) && (act_q == ACT_OBSERVE) && col_ok_q;

	// Load the output register once it is free or being read
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Unloaded columns weigh 1.0
	assign wgt_eff = rd_wset_q ? rd_wgt_q : WEIGHT_ONE;

	// Shared divide step: shift in next numerator bit, compare and subtract
	assign rem_ext  = {rem_q, num_lo_q[NORM_W-1]};
	assign rem_diff = {1'b0, rem_ext} - {2'b00, range_q};
	assign div_ge   = !rem_diff[SAMPLE_W+1];

	// Statistics memories, read at the held column every cycle
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			if (!seen_q[idx_q] || (sample_q < rd_min_q)) begin
				min_mem[idx_q] <= sample_q;
			end
			if (!seen_q[idx_q] || (sample_q > rd_max_q)) begin
				max_mem[idx_q] <= sample_q;
			end
		end
		rd_min_q <= min_mem[idx_q];
		rd_max_q <= max_mem[idx_q];
	end

	// Weight memory, written on load at accept
	always_ff @(posedge clk) begin
		if (accept && (action == ACT_LOAD_WGT) && in_col_ok) begin
			wgt_mem[in_idx] <= weight;
		end
		rd_wgt_q <= wgt_mem[idx_q];
	end

	// Sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= '0;
			wset_q      <= '0;
			out_valid_q <= 1'b0;
			rd_wset_q   <= 1'b0;
			act_q       <= ACT_CLEAR;
			col_q       <= '0;
			idx_q       <= '0;
			col_ok_q    <= 1'b0;
			cnt_q       <= '0;
			stat_q      <= STAT_OK;
		end else begin
			rd_wset_q <= wset_q[idx_q];
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q    <= action;
						col_q    <= column;
						idx_q    <= in_idx;
						col_ok_q <= in_col_ok;
						sample_q <= sample;
						case (action)
							ACT_CLEAR: begin
								seen_q <= '0;
							end
							ACT_LOAD_WGT: begin
								if (in_col_ok) begin
									wset_q[in_idx] <= 1'b1;
								end
							end
							default: begin
								state_q <= ST_RD;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					if (act_q == ACT_OBSERVE) begin
						if (col_ok_q) begin
							seen_q[idx_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else if (!col_ok_q || !seen_q[idx_q]) begin
						quo_q   <= '0;
						stat_q  <= STAT_NO_DATA;
						state_q <= ST_OUT;
					end else if (rd_max_q == rd_min_q) begin
						quo_q   <= '0;
						stat_q  <= STAT_OK;
						state_q <= ST_OUT;
					end else begin
						range_q <= SAMPLE_W'(rd_max_q - rd_min_q);
						off_q   <= {sample_q[SAMPLE_W-1], sample_q}
							- {rd_min_q[SAMPLE_W-1], rd_min_q};
						stat_q  <= STAT_OK;
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					// Clamp offset to [0, range]
					if (off_q[SAMPLE_W]) begin
						offc_q <= '0;
					end else if (off_q[SAMPLE_W-1:0] > range_q) begin
						offc_q <= range_q;
					end else begin
						offc_q <= off_q[SAMPLE_W-1:0];
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(offc_q) * PROD_W'(wgt_eff);
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					// Numerator is prod*256; its top bits are below the range
					rem_q    <= prod_q[PROD_W-1:NORM_W-8];
					num_lo_q <= {prod_q[NORM_W-9:0], 8'h00};
					quo_q    <= '0;
					cnt_q    <= CNT_W'(DIV_STEPS - 1);
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					rem_q    <= div_ge ? rem_diff[SAMPLE_W-1:0] : rem_ext[SAMPLE_W-1:0];
					num_lo_q <= {num_lo_q[NORM_W-2:0], 1'b0};
					quo_q    <= {quo_q[NORM_W-2:0], div_ge};
					cnt_q    <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// Hand the result over once the output register is free
					if (out_load) begin
						normalized_q    <= quo_q;
						result_column_q <= col_q;
						status_q        <= stat_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign normalized    = normalized_q;
	assign result_column = result_column_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	// Remainder stays below the divisor during the divide
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < range_q))
		else $error("divider remainder not below range");

	// No-data results carry a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STAT_NO_DATA)) |-> (normalized == '0))
		else $error("no-data result with nonzero value");

	// A new result appears only from the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(out_valid_q) && out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside output state");

	// Observe and normalize requests hold off the next request
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((action == ACT_OBSERVE) || (action == ACT_NORMALIZE)))
		|=> !in_ready)
		else $error("request accepted while busy");
`endif

endmodule
